/* hdl/bbpt_pkg.sv */
// Shared types and constants for the bar/beat position tracker.
// No dependencies.
package bbpt_pkg;
    localparam int MaxBeats = 4096;
    localparam int IdxW = $clog2(MaxBeats);
    localparam int CntW = IdxW + 1;
    localparam int BarW = 13;
    localparam logic [BarW-1:0] BarMax = 13'd8191;
    localparam logic [16:0] FracOne = 17'h10000;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [31:0] time_ms;
        logic [3:0] beat_in_bar;
    } t_in;

    typedef struct packed {
        logic beat_trigger;
        logic bar_trigger;
        logic [12:0] bar_count;
        logic [3:0] beat_count;
        logic [16:0] beat_fraction;
        logic [16:0] bar_fraction;
        logic table_empty;
    } t_out;

    // datapath commands
    localparam logic [3:0] C_NONE = 4'd0;
    localparam logic [3:0] C_LOAD = 4'd1;
    localparam logic [3:0] C_RD = 4'd2;
    localparam logic [3:0] C_HINT = 4'd3;
    localparam logic [3:0] C_SCAN = 4'd4;
    localparam logic [3:0] C_BACK = 4'd5;
    localparam logic [3:0] C_FWD = 4'd6;
    localparam logic [3:0] C_DIV = 4'd7;

    typedef struct packed {
        logic [3:0] cmd;
        logic [IdxW-1:0] addr;
    } t_ctl;

    typedef struct packed {
        logic [31:0] t;
        logic [3:0] b;
        logic [BarW-1:0] bar;
        logic div_done;
    } t_sts;
endpackage

/* hdl/bbpt_div.sv */
// Restoring Q1.16 ratio unit, one quotient bit per cycle.
// Uses bbpt_pkg.
module bbpt_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_t,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [16:0] o_q
);
    logic [32:0] r_den, n_num, n_den;
    logic [33:0] r_rem;
    logic [16:0] r_q;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [32:0] nu, de;
    logic [33:0] sh;
    always_comb begin
        nu = {1'b0, i_t} - {1'b0, i_a};
        de = {1'b0, i_b} - {1'b0, i_a};
        n_num = de[32] ? (33'd0 - nu) : nu;
        n_den = de[32] ? (33'd0 - de) : de;
        sh = {r_rem[32:0], 1'b0};
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den <= n_den;
                r_rem <= {1'b0, n_num};
                r_cnt <= 5'd0;
                r_q <= 17'd0;
                if (n_den == 33'd0 || (!n_num[32] && n_num >= n_den)) begin
                    r_q <= bbpt_pkg::FracOne;
                    r_done <= 1'b1;
                end else if (n_num[32] || n_num == 33'd0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (sh >= {1'b0, r_den}) begin
                    r_rem <= sh - {1'b0, r_den};
                    r_q <= {r_q[15:0], 1'b1};
                end else begin
                    r_rem <= sh;
                    r_q <= {r_q[15:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_q = r_q;
endmodule

/* hdl/bbpt_datapath.sv */
// Beat table memories, read register and ratio unit.
// Uses bbpt_pkg and bbpt_div.
module bbpt_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bbpt_pkg::t_ctl         i_ctl,
    input  logic                   i_we,
    input  logic [bbpt_pkg::IdxW-1:0] i_waddr,
    input  logic [31:0]            i_wt,
    input  logic [3:0]             i_wb,
    input  logic [bbpt_pkg::BarW-1:0] i_wbar,
    input  logic                   i_div_start,
    input  logic [31:0]            i_dt,
    input  logic [31:0]            i_da,
    input  logic [31:0]            i_db,
    output logic [16:0]            o_q,
    output bbpt_pkg::t_sts         o_sts
);
    logic [31:0] r_tm [bbpt_pkg::MaxBeats];
    logic [3:0]  r_bm [bbpt_pkg::MaxBeats];
    logic [bbpt_pkg::BarW-1:0] r_barm [bbpt_pkg::MaxBeats];
    logic [31:0] r_t;
    logic [3:0]  r_b;
    logic [bbpt_pkg::BarW-1:0] r_bar;
    logic done;
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_tm[i_waddr] <= i_wt;
            r_bm[i_waddr] <= i_wb;
            r_barm[i_waddr] <= i_wbar;
        end
        if (i_ctl.cmd != bbpt_pkg::C_NONE) begin
            r_t <= r_tm[i_ctl.addr];
            r_b <= r_bm[i_ctl.addr];
            r_bar <= r_barm[i_ctl.addr];
        end
    end
    bbpt_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_div_start),
        .i_t(i_dt), .i_a(i_da), .i_b(i_db), .o_done(done), .o_q(o_q)
    );
    assign o_sts = '{t: r_t, b: r_b, bar: r_bar, div_done: done};
endmodule

/* hdl/bbpt_ctrl.sv */
// Sequencer: loading, beat search, bar edge walks and fraction divisions.
// Uses bbpt_pkg.
module bbpt_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  bbpt_pkg::t_in          i_data,
    output logic                   o_valid,
    input  logic                   i_stall,
    output bbpt_pkg::t_out         o_data,
    output bbpt_pkg::t_ctl         o_ctl,
    output logic                   o_we,
    output logic [bbpt_pkg::IdxW-1:0] o_waddr,
    output logic [bbpt_pkg::BarW-1:0] o_wbar,
    output logic                   o_div_start,
    output logic [31:0]            o_dt,
    output logic [31:0]            o_da,
    output logic [31:0]            o_db,
    input  logic [16:0]            i_q,
    input  bbpt_pkg::t_sts         i_sts
);
    localparam int IW = bbpt_pkg::IdxW;
    localparam int CW = bbpt_pkg::CntW;
    localparam logic [3:0] S_IDLE = 4'd0, S_H0 = 4'd1, S_H1 = 4'd2, S_H2 = 4'd3,
        S_SC = 4'd4, S_I0 = 4'd5, S_I1 = 4'd6, S_BK = 4'd7, S_FW = 4'd8,
        S_D1 = 4'd9, S_D2 = 4'd10, S_OUT = 4'd11;

    logic [3:0] r_st;
    logic [CW-1:0] r_n;
    logic [bbpt_pkg::BarW-1:0] r_barc;
    logic [IW-1:0] r_cur, r_idx, r_k;
    logic [31:0] r_prev, r_time, r_th, r_ti, r_tn, r_ts, r_te;
    logic [CW-1:0] r_i;
    logic [3:0] r_bi;
    logic [bbpt_pkg::BarW-1:0] r_bari;
    logic r_trig, r_wait;
    logic [16:0] r_bf;
    bbpt_pkg::t_out r_out;
    logic r_ov;
    logic [IW-1:0] hi, h;
    logic [CW-1:0] nm2;
    logic [3:0] ctl_cmd;
    logic [IW-1:0] ctl_addr;

    always_comb begin
        nm2 = r_n - CW'(2);
        hi = (r_n >= CW'(2)) ? nm2[IW-1:0] : '0;
        h = (r_cur > hi) ? hi : r_cur;
    end

    assign o_stall = (r_st != S_IDLE) || r_ov;
    assign o_valid = r_ov;
    assign o_data = r_out;
    assign o_we = i_valid && !o_stall && i_data.op == bbpt_pkg::OP_APPEND
        && r_n != CW'(bbpt_pkg::MaxBeats);
    assign o_waddr = r_n[IW-1:0];
    assign o_wbar = (i_data.beat_in_bar == 4'd1 && r_barc < bbpt_pkg::BarMax)
        ? r_barc + 1'b1 : r_barc;

    always_comb begin
        ctl_cmd = bbpt_pkg::C_RD;
        ctl_addr = r_k;
        case (r_st)
            S_IDLE: begin ctl_addr = h; ctl_cmd = bbpt_pkg::C_HINT; end
            S_H0, S_H1: ctl_addr = h + 1'b1;
            S_SC: ctl_addr = r_i[IW-1:0];
            default: ctl_addr = r_k;
        endcase
    end
    assign o_ctl = '{cmd: ctl_cmd, addr: ctl_addr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_n <= '0;
            r_barc <= '0;
            r_cur <= '0;
            r_prev <= '0;
            r_ov <= 1'b0;
            o_div_start <= 1'b0;
        end else begin
            o_div_start <= 1'b0;
            if (r_ov && !i_stall) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_time <= i_data.time_ms;
                        case (i_data.op)
                            bbpt_pkg::OP_CLEAR: begin
                                r_n <= '0;
                                r_barc <= '0;
                            end
                            bbpt_pkg::OP_APPEND: begin
                                if (o_we) begin
                                    r_barc <= o_wbar;
                                    r_n <= r_n + 1'b1;
                                end
                            end
                            bbpt_pkg::OP_TICK: begin
                                if (r_n == '0) begin
                                    r_prev <= i_data.time_ms;
                                    r_out <= '{table_empty: 1'b1, default: '0};
                                    r_ov <= 1'b1;
                                end else begin
                                    r_k <= h;
                                    r_st <= S_H0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_H0: begin r_th <= i_sts.t; r_st <= S_H1; end
                S_H1: r_st <= S_H2;
                S_H2: begin
                    if (r_n >= CW'(2) && r_th < r_time && i_sts.t > r_time) begin
                        r_idx <= r_k;
                        r_st <= S_I0;
                    end else begin
                        r_i <= CW'(1);
                        r_wait <= 1'b1;
                        r_st <= S_SC;
                    end
                end
                S_SC: begin
                    // issue the read first, compare it in the next cycle
                    if (r_wait) begin
                        if (r_i >= r_n) begin
                            r_idx <= r_i[IW-1:0] - 1'b1;
                            r_st <= S_I0;
                        end else r_wait <= 1'b0;
                    end else if (i_sts.t <= r_time) begin
                        r_i <= r_i + 1'b1;
                        r_wait <= 1'b1;
                    end else begin
                        r_idx <= r_i[IW-1:0] - 1'b1;
                        r_st <= S_I0;
                    end
                end
                S_I0: begin r_k <= r_idx; r_wait <= 1'b1; r_st <= S_I1; end
                S_I1: begin
                    if (r_wait) r_wait <= 1'b0;
                    else begin
                        r_cur <= r_idx;
                        r_ti <= i_sts.t;
                        r_bi <= i_sts.b;
                        r_bari <= i_sts.bar;
                        r_trig <= i_sts.t >= r_prev;
                        r_prev <= r_time;
                        r_ts <= i_sts.t;
                        r_tn <= i_sts.t;
                        if (i_sts.b == 4'd1 || r_idx == '0) begin
                            r_k <= r_idx;
                            r_st <= S_FW;
                        end else begin
                            r_k <= r_idx - 1'b1;
                            r_st <= S_BK;
                        end
                        r_wait <= 1'b1;
                    end
                end
                S_BK: begin
                    if (r_wait) r_wait <= 1'b0;
                    else if (i_sts.b == 4'd1 || r_k == '0) begin
                        r_ts <= i_sts.t;
                        r_k <= r_idx;
                        r_wait <= 1'b1;
                        r_st <= S_FW;
                    end else begin
                        r_k <= r_k - 1'b1;
                        r_wait <= 1'b1;
                    end
                end
                S_FW: begin
                    // r_k holds entry under test; stops at bar change or last
                    if (r_wait) r_wait <= 1'b0;
                    else begin
                        if (r_k == r_idx + 1'b1) r_tn <= i_sts.t;
                        if ({1'b0, r_k} + 1'b1 < r_n && (r_k == r_idx
                            || i_sts.bar == r_bari)) begin
                            r_k <= r_k + 1'b1;
                            r_wait <= 1'b1;
                        end else begin
                            r_te <= i_sts.t;
                            o_div_start <= 1'b1;
                            r_st <= S_D1;
                        end
                    end
                end
                S_D1: if (i_sts.div_done) begin
                    r_bf <= ({1'b0, r_idx} + 1'b1 < r_n) ? i_q : bbpt_pkg::FracOne;
                    o_div_start <= 1'b1;
                    r_st <= S_D2;
                end
                S_D2: if (i_sts.div_done) begin
                    r_out <= '{beat_trigger: r_trig, bar_trigger: r_trig && r_bi == 4'd1,
                        bar_count: r_bari, beat_count: r_bi, beat_fraction: r_bf,
                        bar_fraction: i_q, table_empty: 1'b0};
                    r_ov <= 1'b1;
                    r_st <= S_OUT;
                end
                S_OUT: r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // beat span in the first division, bar span in the second
    always_comb begin
        o_dt = r_time;
        o_da = (r_st == S_D1) ? r_ti : r_ts;
        o_db = (r_st == S_D1) ? r_tn : r_te;
    end
endmodule

/* hdl/bar_beat_position_tracker_core.sv */
// Top level of the bar/beat position tracker.
// Uses bbpt_pkg, bbpt_ctrl, bbpt_datapath.
// Loads and clears do not leave the idle state. A tick whose hint hits finds and
// reads its beat, then walks back entry by entry to the bar start and forward entry
// by entry to the next bar, then runs two divisions (16 quotient bits each; a
// saturated or zero ratio needs no iterations). A missed hint adds a linear scan
// from entry 1. All reads go through one memory read port. The result is held
// until taken, and the input stays stalled until then.
module bar_beat_position_tracker_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  bbpt_pkg::t_in     i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output bbpt_pkg::t_out    o_data
);
    bbpt_pkg::t_ctl ctl;
    bbpt_pkg::t_sts sts;
    logic we, ds;
    logic [bbpt_pkg::IdxW-1:0] wa;
    logic [bbpt_pkg::BarW-1:0] wbar;
    logic [31:0] dt, da, db;
    logic [16:0] q;

    bbpt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .o_ctl(ctl), .o_we(we), .o_waddr(wa), .o_wbar(wbar), .o_div_start(ds),
        .o_dt(dt), .o_da(da), .o_db(db), .i_q(q), .i_sts(sts)
    );
    bbpt_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .i_we(we), .i_waddr(wa),
        .i_wt(i_data.time_ms), .i_wb(i_data.beat_in_bar), .i_wbar(wbar),
        .i_div_start(ds), .i_dt(dt), .i_da(da), .i_db(db), .o_q(q), .o_sts(sts)
    );

`ifndef NO_ASSERTIONS
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("accept while result pending");
    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.table_empty) |-> (o_data.bar_count == '0
        && !o_data.beat_trigger)) else $error("empty result not clean");
    a_bar_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.bar_trigger) |-> o_data.beat_trigger)
        else $error("bar trigger without beat");
`endif
endmodule
